// ===== hdl/gglap_pkg.sv =====
// Shared types, constants and table builder for the Gaussian graph Laplacian unit.
package gglap_pkg;

  localparam int CoordW   = 16;
  localparam int IndexW   = 6;
  localparam int CountW   = 7;
  localparam int ThreshW  = 34;
  localparam int InvEpsW  = 16;
  localparam int EntryW   = 23;
  localparam int WeightW  = 16;
  localparam int SumW     = 22;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 34;
  localparam int PointW   = 3 * CoordW;

  localparam logic [CfgIdxW-1:0] CfgPointsInUse = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgThreshold   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgInvEpsilon  = 2'd2;

  localparam logic [CountW-1:0]  PointsInUseRst = 7'd64;
  localparam logic [ThreshW-1:0] ThresholdRst   = 34'd135813;
  localparam logic [InvEpsW-1:0] InvEpsilonRst  = 16'd1707;

  localparam logic OpStore = 1'b0;
  localparam logic OpQuery = 1'b1;

  typedef enum logic [2:0] {
    StIdle,
    StRow,
    StStream,
    StDrain,
    StDone
  } state_e;

  typedef struct packed {
    logic store;
    logic start;
    logic issue_row;
    logic issue;
    logic step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic in_range;
    logic last;
    logic pipe_busy;
    logic out_free;
  } status_t;

  // Entry k of exp(-x) over [0,16) in Q0.16; step is 16 in Q.32 over table depth.
  function automatic logic [WeightW-1:0] exp_entry(input int k, input logic [63:0] step);
    logic [63:0] term;
    logic [63:0] g;
    logic [63:0] acc;
    logic [63:0] e;
    term = 64'd1 << 32;
    g    = 64'd1 << 32;
    acc  = 64'd1 << 32;
    for (int i = 1; i <= 12; i++) begin
      term = ((term * step) >> 32) / 64'(i);
      if (i % 2 == 1) g = g - term;
      else g = g + term;
    end
    for (int j = 0; j < k; j++) begin
      acc = (acc * g + (64'd1 << 31)) >> 32;
    end
    e = (acc + 64'd32768) >> 16;
    return (e > 64'd65535) ? 16'hFFFF : e[WeightW-1:0];
  endfunction

endpackage

// ===== hdl/gglap_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gglap_ram #(
  parameter int Width = 48,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/gglap_dp.sv =====
// Datapath: config registers, point store, distance/weight pipeline, accumulator, result register.
module gglap_dp
  import gglap_pkg::*;
#(
  parameter int MAX_POINTS      = 64,
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CfgIdxW-1:0]         cfg_index_i,
  input  logic [CfgDataW-1:0]        cfg_wdata_i,
  input  logic [IndexW-1:0]          row_index_i,
  input  logic [IndexW-1:0]          col_index_i,
  input  logic signed [CoordW-1:0]   coord_x_i,
  input  logic signed [CoordW-1:0]   coord_y_i,
  input  logic signed [CoordW-1:0]   coord_z_i,
  input  cmd_t                       cmd_i,
  output status_t                    status_o,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic signed [EntryW-1:0]   entry_value_o
);

  localparam int AddrW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int NumW    = $clog2(MAX_POINTS + 1);
  localparam int CmpW    = (NumW > CountW) ? NumW : CountW;
  localparam int TIdxW   = $clog2(EXP_TABLE_DEPTH);
  localparam int DepW    = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int ProdW   = 28 + DepW;
  localparam int Stages  = 7;
  localparam logic [63:0] ExpStep = (64'd1 << 36) / EXP_TABLE_DEPTH;
  localparam logic [CmpW-1:0] MaxPts = CmpW'(MAX_POINTS);

  // Configuration registers
  logic [CountW-1:0]  piu_q;
  logic [ThreshW-1:0] thr_q;
  logic [InvEpsW-1:0] inv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      piu_q <= PointsInUseRst;
      thr_q <= ThresholdRst;
      inv_q <= InvEpsilonRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgPointsInUse: piu_q <= cfg_wdata_i[CountW-1:0];
        CfgThreshold:   thr_q <= cfg_wdata_i[ThreshW-1:0];
        CfgInvEpsilon:  inv_q <= cfg_wdata_i[InvEpsW-1:0];
        default: ;
      endcase
    end
  end

  // Exponential table, built at elaboration
  logic [WeightW-1:0] exp_rom [EXP_TABLE_DEPTH];
  for (genvar k = 0; k < EXP_TABLE_DEPTH; k++) begin : g_rom
    localparam logic [WeightW-1:0] Val = exp_entry(k, ExpStep);
    assign exp_rom[k] = Val;
  end

  // Query registers
  logic [IndexW-1:0] row_q, col_q;
  logic              diag_q;
  logic [AddrW-1:0]  j_q;
  logic [CmpW-1:0]   n, rowx, colx, in_rowx;
  logic [AddrW-1:0]  row_addr, col_addr;

  assign n        = (CmpW'(piu_q) > MaxPts) ? MaxPts : CmpW'(piu_q);
  assign rowx     = CmpW'(row_q);
  assign colx     = CmpW'(col_q);
  assign in_rowx  = CmpW'(row_index_i);
  assign row_addr = rowx[AddrW-1:0];
  assign col_addr = colx[AddrW-1:0];

  function automatic logic [AddrW-1:0] col_addr_in(input logic [IndexW-1:0] c);
    logic [CmpW-1:0] cx;
    cx = CmpW'(c);
    return cx[AddrW-1:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      row_q  <= row_index_i;
      col_q  <= col_index_i;
      diag_q <= (row_index_i == col_index_i);
      j_q    <= (row_index_i == col_index_i) ? '0 : col_addr_in(col_index_i);
    end else if (cmd_i.step) begin
      j_q <= j_q + AddrW'(1);
    end
  end

  assign status_o.in_range = (rowx < n) && (colx < n);
  assign status_o.last     = !diag_q || (CmpW'(j_q) == n - CmpW'(1));

  // Point store
  logic              ram_we;
  logic [AddrW-1:0]  ram_raddr;
  logic [PointW-1:0] ram_rdata;

  assign ram_we    = cmd_i.store && (in_rowx < MaxPts);
  assign ram_raddr = cmd_i.issue_row ? row_addr : j_q;

  gglap_ram #(
    .Width(PointW),
    .Depth(MAX_POINTS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(in_rowx[AddrW-1:0]),
    .wdata_i({coord_z_i, coord_y_i, coord_x_i}),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Row point capture in the cycle after its read
  logic              rowrd_q;
  logic [PointW-1:0] rowpt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rowrd_q <= 1'b0;
    else rowrd_q <= cmd_i.issue_row;
  end

  always_ff @(posedge clk_i) begin
    if (rowrd_q) rowpt_q <= ram_rdata;
  end

  // Tag pipeline: set for each issued point that contributes to the sum
  logic [Stages-1:0] tag_q;
  logic              use_pt;

  assign use_pt = cmd_i.issue && (!diag_q || (j_q != row_addr));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) tag_q <= '0;
    else tag_q <= {tag_q[Stages-2:0], use_pt};
  end

  assign status_o.pipe_busy = |tag_q;

  // Stage 1: coordinate differences
  logic signed [CoordW:0] dx_q, dy_q, dz_q;

  always_ff @(posedge clk_i) begin
    dx_q <= (CoordW+1)'($signed(ram_rdata[CoordW-1:0]))
          - (CoordW+1)'($signed(rowpt_q[CoordW-1:0]));
    dy_q <= (CoordW+1)'($signed(ram_rdata[2*CoordW-1:CoordW]))
          - (CoordW+1)'($signed(rowpt_q[2*CoordW-1:CoordW]));
    dz_q <= (CoordW+1)'($signed(ram_rdata[3*CoordW-1:2*CoordW]))
          - (CoordW+1)'($signed(rowpt_q[3*CoordW-1:2*CoordW]));
  end

  // Stage 2: squares
  logic signed [2*CoordW+1:0] sqx, sqy, sqz;
  logic [2*CoordW-1:0]        sqx_q, sqy_q, sqz_q;

  assign sqx = dx_q * dx_q;
  assign sqy = dy_q * dy_q;
  assign sqz = dz_q * dz_q;

  always_ff @(posedge clk_i) begin
    sqx_q <= sqx[2*CoordW-1:0];
    sqy_q <= sqy[2*CoordW-1:0];
    sqz_q <= sqz[2*CoordW-1:0];
  end

  // Stage 3: squared distance
  logic [ThreshW-1:0] dist_q;

  always_ff @(posedge clk_i) begin
    dist_q <= ThreshW'(sqx_q) + ThreshW'(sqy_q) + ThreshW'(sqz_q);
  end

  // Stage 4: threshold test and scale; a distance at or above 2^28 overruns the table
  logic [27+InvEpsW:0] p_q;
  logic                ok4_q;

  always_ff @(posedge clk_i) begin
    ok4_q <= (dist_q < thr_q) && ((inv_q == '0) || (dist_q[ThreshW-1:28] == '0));
    p_q   <= dist_q[27:0] * inv_q;
  end

  // Stage 5: table index
  logic [ProdW-1:0] iprod;
  logic [TIdxW-1:0] idx_q;
  logic             ok5_q;

  assign iprod = ProdW'(p_q[27:0]) * ProdW'(EXP_TABLE_DEPTH);

  always_ff @(posedge clk_i) begin
    ok5_q <= ok4_q && (p_q[27+InvEpsW:28] == '0);
    idx_q <= iprod[28 +: TIdxW];
  end

  // Stage 6: weight lookup
  logic [WeightW-1:0] w_q;

  always_ff @(posedge clk_i) begin
    w_q <= ok5_q ? exp_rom[idx_q] : '0;
  end

  // Accumulate with saturation
  logic [SumW-1:0] acc_q;
  logic [SumW:0]   acc_sum;

  assign acc_sum = (SumW+1)'(acc_q) + (SumW+1)'(w_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) acc_q <= '0;
    else if (tag_q[Stages-1]) acc_q <= acc_sum[SumW] ? '1 : acc_sum[SumW-1:0];
  end

  // Result register
  logic                     out_valid_q;
  logic signed [EntryW-1:0] entry_q;

  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.load_out) out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      entry_q <= diag_q ? $signed(EntryW'(acc_q)) : $signed(EntryW'(0) - EntryW'(acc_q));
    end
  end

  assign out_valid_o   = out_valid_q;
  assign entry_value_o = entry_q;

endmodule

// ===== hdl/gglap_ctrl.sv =====
// Controller: sequences stores, row read, point stream, drain and result hand-off.
module gglap_ctrl
  import gglap_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    opcode_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:   if (in_valid_i && opcode_i == OpQuery) state_d = StRow;
      StRow:    state_d = status_i.in_range ? StStream : StDone;
      StStream: if (status_i.last) state_d = StDrain;
      StDrain:  if (!status_i.pipe_busy) state_d = StDone;
      StDone:   if (status_i.out_free) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      StIdle: begin
        in_ready_o  = 1'b1;
        cmd_o.store = in_valid_i && opcode_i == OpStore;
        cmd_o.start = in_valid_i && opcode_i == OpQuery;
      end
      StRow:    cmd_o.issue_row = status_i.in_range;
      StStream: begin
        cmd_o.issue = 1'b1;
        cmd_o.step  = !status_i.last;
      end
      StDrain:  ;
      StDone:   cmd_o.load_out = status_i.out_free;
      default:  ;
    endcase
  end

endmodule

// ===== hdl/gaussian_graph_laplacian_unit.sv =====
// Top level of the Gaussian-kernel graph Laplacian unit.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+---------------------------------------------
//   input    | in_valid_i / in_ready_o | opcode, row/col index, coord_x/y/z
//   result   | out_valid_o/out_ready_i | entry_value (signed, Q0.16 weight units)
//   config   | cfg_we_i                | cfg_index_i, cfg_wdata_i (no read-back)
//
// A store is written straight from the idle state. A query reads its row point, streams
// points through a seven-stage distance/weight pipeline one per cycle, then drains;
// a diagonal entry streams all n points (n = points in use), an off-diagonal one
// only its column point, and an entry outside the graph none. The point stream sets the rate.
// Reset clears control and sets config to its defaults; point contents are undefined until stored.
// A finished result waits in the output register; input stalls only while a
// query runs or a second result finds that register still full.
module gaussian_graph_laplacian_unit
  import gglap_pkg::*;
#(
  parameter int MAX_POINTS      = 64,
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CfgIdxW-1:0]       cfg_index_i,
  input  logic [CfgDataW-1:0]      cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     opcode_i,
  input  logic [IndexW-1:0]        row_index_i,
  input  logic [IndexW-1:0]        col_index_i,
  input  logic signed [CoordW-1:0] coord_x_i,
  input  logic signed [CoordW-1:0] coord_y_i,
  input  logic signed [CoordW-1:0] coord_z_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [EntryW-1:0] entry_value_o
);

  // Commands flow from controller to datapath, status back.
  cmd_t    cmd;
  status_t status;

  gglap_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .opcode_i  (opcode_i),
    .in_ready_o(in_ready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  // Datapath holds config, point store, weight pipeline and the result register.
  gglap_dp #(
    .MAX_POINTS     (MAX_POINTS),
    .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .row_index_i  (row_index_i),
    .col_index_i  (col_index_i),
    .coord_x_i    (coord_x_i),
    .coord_y_i    (coord_y_i),
    .coord_z_i    (coord_z_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .entry_value_o(entry_value_o)
  );

endmodule
